// ----- rtl/core/ptvv_pkg.sv -----
// ----------------------------------------------------------------------------
// ptvv_pkg
// Shared types and constants of the planar tile video-memory viewer.
// ----------------------------------------------------------------------------
package ptvv_pkg;

    localparam int MEM_ADDR_W  = 16;
    localparam int MEM_DATA_W  = 8;
    localparam int MEM_DEPTH   = 65536;
    localparam int COORD_W     = 9;
    localparam int COLOUR_W    = 24;
    localparam int CFG_DATA_W  = 2;
    localparam int PLANE_W     = 3;
    localparam int NREAD_W     = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam logic [COLOUR_W-1:0] BACKGROUND = 24'h800000;

    // register index of the configuration port
    localparam logic [0:0] CFG_VIEW_MODE      = 1'b0;
    localparam logic [0:0] CFG_CONTENT_LOADED = 1'b1;

    // operation code in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        MODE_2BPP = 2'd0,
        MODE_4BPP = 2'd1,
        MODE_8BPP = 2'd2,
        MODE_7    = 2'd3
    } t_view_mode;

    // controller -> datapath
    typedef struct packed {
        logic               capture;   // latch input word
        logic               mem_we;    // store the input byte
        logic               rd_en;     // read one plane byte
        logic [PLANE_W-1:0] plane;     // plane being read
        logic               finish;    // load result into output register
    } t_ptvv_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [NREAD_W-1:0] num_reads; // bytes needed, 0 when outside area
        logic               out_free;  // output register can take a result
    } t_ptvv_status;

endpackage

// ----- rtl/core/ptvv_ram.sv -----
// ----------------------------------------------------------------------------
// ptvv_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptvv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ptvv_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptvv_ctrl
// Sequencer: accepts words, steps plane reads, hands off to output register.
// ----------------------------------------------------------------------------
module ptvv_ctrl import ptvv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_op,
    output logic         o_ready,
    input  t_ptvv_status i_status,
    output t_ptvv_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_LAST,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [PLANE_W-1:0]  r_plane, n_plane;
    logic                accept;
    logic                last_rd;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign last_rd = ({1'b0, r_plane} == (i_status.num_reads - NREAD_W'(1)));

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = accept;
        o_cmd.mem_we  = accept && (i_op == OP_WRITE);
        o_cmd.plane   = r_plane;
        o_cmd.rd_en   = (r_state == S_ISSUE) && (i_status.num_reads != '0);
        o_cmd.finish  = (r_state == S_FINISH) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        unique case (r_state)
            S_IDLE: begin
                n_plane = '0;
                if (accept && (i_op == OP_READ)) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (i_status.num_reads == '0) begin
                    n_state = S_FINISH;
                end else if (last_rd) begin
                    n_state = S_LAST;
                end else begin
                    n_plane = r_plane + PLANE_W'(1);
                end
            end
            S_LAST: begin
                // last byte lands in the datapath this cycle
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plane <= '0;
        end else begin
            r_state <= n_state;
            r_plane <= n_plane;
        end
    end

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> ({1'b0, r_plane} < i_status.num_reads))
        else $error("plane read beyond needed count");

    a_last_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LAST |=> r_state == S_FINISH)
        else $error("last read not followed by finish");

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_we |-> !o_cmd.rd_en && !o_cmd.finish)
        else $error("memory write collides with read sequence");

endmodule

// ----- rtl/core/ptvv_datapath.sv -----
// ----------------------------------------------------------------------------
// ptvv_datapath
// Config registers, video memory, address generation, index gather and
// output register.
// ----------------------------------------------------------------------------
module ptvv_datapath import ptvv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [MEM_ADDR_W-1:0] i_byte_address,
    input  logic [MEM_DATA_W-1:0] i_byte_value,
    input  logic [COORD_W-1:0]    i_pixel_x,
    input  logic [COORD_W-1:0]    i_pixel_y,
    input  t_ptvv_cmd             i_cmd,
    output t_ptvv_status          o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COLOUR_W-1:0]   o_pixel_colour,
    output logic                  o_inside_area
);

    t_view_mode            r_view_mode;
    logic                  r_loaded;
    logic [COORD_W-1:0]    r_x, r_y;
    logic                  r_col_en;
    logic [PLANE_W-1:0]    r_col_plane;
    logic [MEM_DATA_W-1:0] r_index;
    logic                  r_out_valid;
    logic [COLOUR_W-1:0]   r_colour;
    logic                  r_inside;

    logic [5:0]            tx, ty;
    logic [2:0]            px, py;
    logic                  in_area;
    logic [MEM_ADDR_W-1:0] rd_addr, mem_addr;
    logic [MEM_DATA_W-1:0] rdata, grey;
    logic [NREAD_W-1:0]    num_reads;

    assign tx = r_x[8:3];
    assign px = r_x[2:0];
    assign ty = r_y[8:3];
    assign py = r_y[2:0];

    always_comb begin
        unique case (r_view_mode)
            MODE_2BPP: begin
                in_area   = r_loaded;
                num_reads = NREAD_W'(2);
                rd_addr   = {ty, tx, py, i_cmd.plane[0]};
            end
            MODE_4BPP: begin
                in_area   = r_loaded && (ty[5] == 1'b0);
                num_reads = NREAD_W'(4);
                rd_addr   = {ty[4:0], tx, i_cmd.plane[1], py, i_cmd.plane[0]};
            end
            MODE_8BPP: begin
                in_area   = r_loaded && (ty[5:4] == 2'b00);
                num_reads = NREAD_W'(8);
                rd_addr   = {ty[3:0], tx, i_cmd.plane[2:1], py, i_cmd.plane[0]};
            end
            MODE_7: begin
                // one pixel per word, colour is the odd byte
                in_area   = r_loaded && (ty[5:4] == 2'b00) && (tx[5:4] == 2'b00);
                num_reads = NREAD_W'(1);
                rd_addr   = {1'b0, ty[3:0], tx[3:0], py, px, 1'b1};
            end
            default: begin
                in_area   = 1'b0;
                num_reads = '0;
                rd_addr   = '0;
            end
        endcase
    end

    assign o_status.num_reads = in_area ? num_reads : '0;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign mem_addr = i_cmd.mem_we ? i_byte_address : rd_addr;

    ptvv_ram #(
        .WIDTH (MEM_DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_byte_value),
        .o_rdata (rdata)
    );

    always_comb begin
        unique case (r_view_mode)
            MODE_2BPP: grey = {4{r_index[1:0]}};
            MODE_4BPP: grey = {2{r_index[3:0]}};
            default:   grey = r_index;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_mode <= MODE_2BPP;
            r_loaded    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VIEW_MODE:      r_view_mode <= t_view_mode'(i_cfg_data);
                CFG_CONTENT_LOADED: r_loaded    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_en <= 1'b0;
        end else begin
            r_col_en <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_plane <= i_cmd.plane;
        if (i_cmd.capture) begin
            r_x     <= i_pixel_x;
            r_y     <= i_pixel_y;
            r_index <= '0;
        end else if (r_col_en) begin
            if (r_view_mode == MODE_7) begin
                r_index <= rdata;
            end else begin
                // column 0 takes the msb of each plane byte
                r_index[r_col_plane] <= rdata[~px];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_colour <= in_area ? {grey, grey, grey} : BACKGROUND;
            r_inside <= in_area;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_colour = r_colour;
    assign o_inside_area  = r_inside;

    a_collect_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |=> r_col_en)
        else $error("read data not collected");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites pending output word");

endmodule

// ----- rtl/core/planar_tile_vram_viewer.sv -----
// ----------------------------------------------------------------------------
// planar_tile_vram_viewer
// 64 KiB byte-written video memory with a planar tile pixel decoder.
// ----------------------------------------------------------------------------
// Write word: stored in the accept cycle, one write per cycle sustained.
// Read word: n bytes read one per cycle from single-port memory after accept;
// result goes to output register once it is free, then next word taken: n = 2
// (2bpp), 4 (4bpp), 8 (8bpp), 1 (mode 7), 0 outside area or content not loaded.
// The next word is taken while a result waits in the output register.
// Synchronous active-low reset clears control and config, not data or memory.
module planar_tile_vram_viewer import ptvv_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] byte_address, [23:16] byte_value, [32:24] pixel_x,
    // [41:33] pixel_y, [47:42] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]             s_axis_tuser,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [23:0] pixel_colour
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] inside_area
    output logic [0:0]             m_axis_tuser
);

    t_ptvv_cmd    cmd;
    t_ptvv_status status;
    logic         inside_area;

    ptvv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser[0]),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ptvv_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_byte_address (s_axis_tdata[15:0]),
        .i_byte_value   (s_axis_tdata[23:16]),
        .i_pixel_x      (s_axis_tdata[32:24]),
        .i_pixel_y      (s_axis_tdata[41:33]),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_pixel_colour (m_axis_tdata),
        .o_inside_area  (inside_area)
    );

    assign m_axis_tuser = inside_area;

endmodule
